FILE: hw/rtl/tkr_pkg.sv
// Package of the top-k rate table: entry record, cell commands and codes.
// Used by the cell, the top level and the checker; depends on nothing else.
`default_nettype none

package tkr_pkg;

	localparam int ID_W   = 16;
	localparam int RATE_W = 32;
	localparam int TIME_W = 32;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic REG_SELF_ID = 1'b0;
	localparam logic REG_EXPIRY  = 1'b1;

	localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd7000;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [RATE_W-1:0] rate;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef enum logic [3:0] {
		CELL_HOLD  = 4'b0001,
		CELL_WRITE = 4'b0010,
		CELL_MARK  = 4'b0100,
		CELL_SORT  = 4'b1000
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic              odd_phase;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] expiry;
	} cell_ctrl_t;

	// Live entries come before dead ones; among live ones, higher rate first.
	// Equal keys never swap, which keeps the sort stable.
	function automatic logic swap_needed(input logic left_live,
			input logic [RATE_W-1:0] left_rate, input logic right_live,
			input logic [RATE_W-1:0] right_rate);
		swap_needed = (!left_live && right_live) ||
			(left_live && right_live && (left_rate < right_rate));
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tkr_cell.sv
// One slot of the table: holds an entry and its live flag, marks expiry and
// exchanges its entry with a neighbor during the odd-even sort. Uses tkr_pkg.
`default_nettype none

module tkr_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tkr_pkg::cell_ctrl_t ctrl,
	input  wire logic               wr_en,
	input  wire tkr_pkg::entry_t    wr_data,
	input  wire logic               in_range,
	input  wire logic               odd_slot,
	input  wire logic               has_left,
	input  wire logic               has_right,
	input  wire tkr_pkg::entry_t    left_entry,
	input  wire logic               left_live,
	input  wire tkr_pkg::entry_t    right_entry,
	input  wire logic               right_live,
	output tkr_pkg::entry_t         entry,
	output logic                    live
);
	import tkr_pkg::*;

	entry_t            entry_q;
	entry_t            entry_d;
	logic              live_q;
	logic              live_d;
	logic              role_left;
	logic [TIME_W-1:0] age;

	assign role_left = (odd_slot == ctrl.odd_phase);
	assign age       = ctrl.now - entry_q.stamp;

	always_comb begin
		entry_d = entry_q;
		live_d  = live_q;
		unique case (ctrl.cmd)
			CELL_HOLD: begin
			end
			CELL_WRITE: begin
				if (wr_en) begin
					entry_d = wr_data;
				end
			end
			CELL_MARK: begin
				live_d = in_range && !(age > ctrl.expiry);
			end
			CELL_SORT: begin
				if (role_left) begin
					if (has_right && swap_needed(live_q, entry_q.rate, right_live,
							right_entry.rate)) begin
						entry_d = right_entry;
						live_d  = right_live;
					end
				end else begin
					if (has_left && swap_needed(left_live, left_entry.rate, live_q,
							entry_q.rate)) begin
						entry_d = left_entry;
						live_d  = left_live;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else begin
			live_q <= live_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	assign live  = live_q;

endmodule

`default_nettype wire

FILE: hw/rtl/top_k_rate_table_with_expiry.sv
// Update: an item is taken in idle and handled in the update state; with a full table
// and no id match the lowest rate is searched one slot a cycle in the evict state, then written.
// Report: expiry marking, odd-even sort in the cell row and counting come
// before the first row, then one row per cycle while taken.
// Reset clears the control state, the self entry and the entry count and sets
// expiry_ms to 7000; table contents stay unknown until written.
// Top level: sequencer around a row of tkr_cell slots. Uses tkr_pkg.
`default_nettype none

module top_k_rate_table_with_expiry #(
	parameter int MAX_OTHERS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // now_ms[31:0], object_id[47:32], rate_value[79:48]
	input  wire logic        s_tuser,   // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // row_id[15:0], row_rate[47:16]
	output logic             m_tuser,   // is_self
	output logic             m_tlast,   // last_row
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	import tkr_pkg::*;

	localparam int IW = (MAX_OTHERS > 1) ? $clog2(MAX_OTHERS) : 1;
	localparam int CW = $clog2(MAX_OTHERS + 1);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b00000001,
		ST_UPDATE = 8'b00000010,
		ST_EVICT  = 8'b00000100,
		ST_WRITE  = 8'b00001000,
		ST_MARK   = 8'b00010000,
		ST_SORT   = 8'b00100000,
		ST_TALLY  = 8'b01000000,
		ST_EMIT   = 8'b10000000
	} state_t;

	state_t             state_q;
	logic [ID_W-1:0]    self_id_q;
	logic [TIME_W-1:0]  expiry_q;
	logic               self_valid_q;
	logic [RATE_W-1:0]  self_rate_q;
	logic [TIME_W-1:0]  self_stamp_q;
	logic               self_live_q;
	logic               self_pend_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      rd_idx_q;
	logic [IW-1:0]      low_q;
	logic [RATE_W-1:0]  low_rate_q;

	logic               op_q;
	logic [TIME_W-1:0]  now_q;
	logic [ID_W-1:0]    obj_q;
	logic [RATE_W-1:0]  rate_q;

	logic               out_valid_q;
	logic               out_self_q;
	logic               out_last_q;
	logic [ID_W-1:0]    out_id_q;
	logic [RATE_W-1:0]  out_rate_q;

	entry_t             cell_entry [MAX_OTHERS];
	logic [MAX_OTHERS-1:0] cell_live;
	logic [MAX_OTHERS-1:0] cell_wr_en;
	logic [MAX_OTHERS-1:0] cell_in_range;
	entry_t             rd_tab [2**IW];
	entry_t             rd_entry;
	entry_t             wr_data;
	cell_ctrl_t         ctrl;

	logic               self_hit;
	logic               match_any;
	logic [IW-1:0]      match_idx;
	logic               count_full;
	logic               wr_go;
	logic [IW-1:0]      wr_idx;
	logic [CW-1:0]      n_live;
	logic [TIME_W-1:0]  self_age;
	logic               out_free;
	logic               in_accept;
	logic               cfg_accept;

	assign s_tready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign in_accept  = s_tvalid && s_tready;
	assign cfg_accept = cfg_valid && cfg_ready;
	assign out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_rate_q, out_id_q};
	assign m_tuser  = out_self_q;
	assign m_tlast  = out_last_q;

	assign self_hit   = (obj_q == self_id_q);
	assign count_full = (count_q == CW'(MAX_OTHERS));
	assign self_age   = now_q - self_stamp_q;
	assign n_live     = CW'($countones(cell_live));
	assign rd_entry   = rd_tab[rd_idx_q];
	assign wr_data    = '{id: obj_q, rate: rate_q, stamp: now_q};

	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		for (int k = 0; k < MAX_OTHERS; k++) begin
			if (!match_any && (CW'(k) < count_q) && (cell_entry[k].id == obj_q)) begin
				match_any = 1'b1;
				match_idx = IW'(k);
			end
		end
	end

	always_comb begin
		wr_go  = 1'b0;
		wr_idx = low_q;
		if (state_q == ST_UPDATE) begin
			wr_go  = !self_hit && (match_any || !count_full);
			wr_idx = match_any ? match_idx : count_q[IW-1:0];
		end else if (state_q == ST_WRITE) begin
			wr_go = 1'b1;
		end
	end

	always_comb begin
		ctrl.now       = now_q;
		ctrl.expiry    = expiry_q;
		ctrl.odd_phase = rd_idx_q[0];
		if (state_q == ST_MARK) begin
			ctrl.cmd = CELL_MARK;
		end else if (state_q == ST_SORT) begin
			ctrl.cmd = CELL_SORT;
		end else if (wr_go) begin
			ctrl.cmd = CELL_WRITE;
		end else begin
			ctrl.cmd = CELL_HOLD;
		end
	end

	for (genvar k = 0; k < MAX_OTHERS; k++) begin : g_cell
		entry_t left_entry;
		entry_t right_entry;
		logic   left_live;
		logic   right_live;

		assign cell_wr_en[k]    = wr_go && (wr_idx == IW'(k));
		assign cell_in_range[k] = (CW'(k) < count_q);

		if (k > 0) begin : g_left
			assign left_entry = cell_entry[k-1];
			assign left_live  = cell_live[k-1];
		end else begin : g_edge_left
			assign left_entry = '0;
			assign left_live  = 1'b0;
		end

		if (k < MAX_OTHERS - 1) begin : g_right
			assign right_entry = cell_entry[k+1];
			assign right_live  = cell_live[k+1];
		end else begin : g_edge_right
			assign right_entry = '0;
			assign right_live  = 1'b0;
		end

		tkr_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.wr_en       (cell_wr_en[k]),
			.wr_data     (wr_data),
			.in_range    (cell_in_range[k]),
			.odd_slot    (1'(k % 2)),
			.has_left    (1'(k > 0)),
			.has_right   (1'(k < MAX_OTHERS - 1)),
			.left_entry  (left_entry),
			.left_live   (left_live),
			.right_entry (right_entry),
			.right_live  (right_live),
			.entry       (cell_entry[k]),
			.live        (cell_live[k])
		);
	end

	for (genvar k = 0; k < 2**IW; k++) begin : g_rd
		if (k < MAX_OTHERS) begin : g_used
			assign rd_tab[k] = cell_entry[k];
		end else begin : g_pad
			assign rd_tab[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			self_id_q    <= '0;
			expiry_q     <= EXPIRY_RESET;
			self_valid_q <= 1'b0;
			self_rate_q  <= '0;
			self_stamp_q <= '0;
			self_live_q  <= 1'b0;
			self_pend_q  <= 1'b0;
			count_q      <= '0;
			rd_idx_q     <= '0;
			low_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_accept) begin
				unique case (cfg_index)
					REG_SELF_ID: self_id_q <= cfg_data[ID_W-1:0];
					REG_EXPIRY:  expiry_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= (s_tuser == OP_REPORT) ? ST_MARK : ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (self_hit) begin
						self_valid_q <= 1'b1;
						self_rate_q  <= rate_q;
						self_stamp_q <= now_q;
						state_q      <= ST_IDLE;
					end else if (match_any) begin
						state_q <= ST_IDLE;
					end else if (!count_full) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_IDLE;
					end else begin
						low_q    <= '0;
						rd_idx_q <= IW'(1);
						state_q  <= (MAX_OTHERS > 1) ? ST_EVICT : ST_WRITE;
					end
				end
				ST_EVICT: begin
					if (rd_entry.rate < low_rate_q) begin
						low_q <= rd_idx_q;
					end
					if (rd_idx_q == IW'(MAX_OTHERS - 1)) begin
						state_q <= ST_WRITE;
					end else begin
						rd_idx_q <= rd_idx_q + IW'(1);
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_MARK: begin
					self_live_q <= self_valid_q && !(self_age > expiry_q);
					rd_idx_q    <= '0;
					state_q     <= ST_SORT;
				end
				ST_SORT: begin
					if (rd_idx_q == IW'(MAX_OTHERS - 1)) begin
						state_q <= ST_TALLY;
					end else begin
						rd_idx_q <= rd_idx_q + IW'(1);
					end
				end
				ST_TALLY: begin
					count_q     <= n_live;
					self_pend_q <= self_live_q;
					rd_idx_q    <= '0;
					state_q     <= (self_live_q || (n_live != '0)) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (self_pend_q) begin
							self_pend_q <= 1'b0;
							if (count_q == '0) begin
								state_q <= ST_IDLE;
							end
						end else if ((CW'(rd_idx_q) + CW'(1)) == count_q) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= s_tuser;
			now_q  <= s_tdata[31:0];
			obj_q  <= s_tdata[47:32];
			rate_q <= s_tdata[79:48];
		end
		if ((state_q == ST_UPDATE) && (op_q == OP_UPDATE)) begin
			low_rate_q <= cell_entry[0].rate;
		end else if ((state_q == ST_EVICT) && (rd_entry.rate < low_rate_q)) begin
			low_rate_q <= rd_entry.rate;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			if (self_pend_q) begin
				out_self_q <= 1'b1;
				out_id_q   <= self_id_q;
				out_rate_q <= self_rate_q;
				out_last_q <= (count_q == '0);
			end else begin
				out_self_q <= 1'b0;
				out_id_q   <= rd_entry.id;
				out_rate_q <= rd_entry.rate;
				out_last_q <= ((CW'(rd_idx_q) + CW'(1)) == count_q);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tkr_checker.sv
// Port-level checks on the top-k rate table and the bind that attaches them.
// Uses tkr_pkg; binds to top_k_rate_table_with_expiry.
`default_nettype none

module tkr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);
	import tkr_pkg::*;

	// A stalled row holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output row changed");

	// The block is busy in the cycle after it takes an update item.
	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_UPDATE) |=> !s_tready)
		else $error("input ready right after an update item");

	// The self row can only open a report.
	a_self_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !(m_tvalid && m_tuser))
		else $error("self row in the middle of a report");

	// No new item is taken while the row on the output is not the last of its report.
	a_report_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready during a report");

endmodule

bind top_k_rate_table_with_expiry tkr_checker u_tkr_checker (.*);

`default_nettype wire

FILE: sim/tb_top_k_rate_table_with_expiry.sv
// Self-checking testbench for top_k_rate_table_with_expiry: a directed table, then random phases.
// It predicts every report row, checks the rows in order, and stalls both streams at random.
// Depends on tkr_pkg and the top level only.
`default_nettype none

module tb_top_k_rate_table_with_expiry;
	import tkr_pkg::*;

	localparam int MAX_OTHERS = 4;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 30;
	localparam int NOT_TYPED = -1;

	typedef struct packed {
		logic              is_self;
		logic [ID_W-1:0]   id;
		logic [RATE_W-1:0] rate;
		logic              last;
	} row_t;

	typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

	typedef struct packed {
		step_kind_t        kind;
		logic              sel;
		logic [TIME_W-1:0] word;
		logic [ID_W-1:0]   id;
		logic [RATE_W-1:0] rate;
		int                n_typed;
		row_t              first;
	} step_t;

	localparam row_t NO_ROW = '0;

	// For items, sel is the operation and word the time; for writes, the index and the data.
	localparam step_t PLAN [22] = '{
		'{STEP_ITEM, OP_REPORT, 32'd0,          16'h0000, 32'h0000_0000, 0, NO_ROW},
		'{STEP_ITEM, OP_UPDATE, 32'd0,          16'h0000, 32'hFFFF_FFFF, 0, NO_ROW},
		'{STEP_ITEM, OP_REPORT, 32'd0,          16'h0000, 32'h0000_0000, 1,
			row_t'{1'b1, 16'h0000, 32'hFFFF_FFFF, 1'b1}},
		'{STEP_ITEM, OP_REPORT, 32'd7000,       16'h0000, 32'h0000_0000, 1,
			row_t'{1'b1, 16'h0000, 32'hFFFF_FFFF, 1'b1}},
		'{STEP_ITEM, OP_REPORT, 32'd7001,       16'h0000, 32'h0000_0000, 0, NO_ROW},
		'{STEP_ITEM, OP_UPDATE, 32'd100,        16'hFFFF, 32'h0000_0005, 0, NO_ROW},
		'{STEP_ITEM, OP_UPDATE, 32'd100,        16'h0001, 32'h0000_0005, 0, NO_ROW},
		'{STEP_ITEM, OP_UPDATE, 32'd100,        16'h0002, 32'h0000_0000, 0, NO_ROW},
		'{STEP_ITEM, OP_UPDATE, 32'd100,        16'h0003, 32'hFFFF_FFFF, 0, NO_ROW},
		'{STEP_ITEM, OP_UPDATE, 32'd100,        16'h0004, 32'h0000_0007, 0, NO_ROW},
		'{STEP_ITEM, OP_UPDATE, 32'd200,        16'h0003, 32'h8000_0000, 0, NO_ROW},
		'{STEP_ITEM, OP_REPORT, 32'd200,        16'h0000, 32'h0000_0000, NOT_TYPED, NO_ROW},
		'{STEP_ITEM, OP_UPDATE, 32'd300,        16'h0006, 32'h0000_0005, 0, NO_ROW},
		'{STEP_CFG,  REG_EXPIRY, 32'd0,         16'h0000, 32'h0000_0000, NOT_TYPED, NO_ROW},
		'{STEP_ITEM, OP_REPORT, 32'd300,        16'h0000, 32'h0000_0000, 1,
			row_t'{1'b0, 16'h0006, 32'h0000_0005, 1'b1}},
		'{STEP_CFG,  REG_EXPIRY, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, NOT_TYPED, NO_ROW},
		'{STEP_CFG,  REG_SELF_ID, 32'h0000_FFFF, 16'h0000, 32'h0000_0000, NOT_TYPED, NO_ROW},
		'{STEP_ITEM, OP_UPDATE, 32'hFFFF_FFFF,  16'hFFFF, 32'h0000_0000, 0, NO_ROW},
		'{STEP_ITEM, OP_REPORT, 32'd0,          16'h0000, 32'h0000_0000, 2,
			row_t'{1'b1, 16'hFFFF, 32'h0000_0000, 1'b0}},
		'{STEP_CFG,  REG_EXPIRY, EXPIRY_RESET,  16'h0000, 32'h0000_0000, NOT_TYPED, NO_ROW},
		'{STEP_ITEM, OP_REPORT, 32'd8000,       16'h0000, 32'h0000_0000, 0, NO_ROW},
		'{STEP_ITEM, OP_REPORT, 32'd3,          16'h0000, 32'h0000_0000, 1,
			row_t'{1'b1, 16'hFFFF, 32'h0000_0000, 1'b1}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;   // now_ms[31:0], object_id[47:32], rate_value[79:48]
	logic        s_tuser = 1'b0; // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // row_id[15:0], row_rate[47:16]
	logic        m_tuser;        // is_self
	logic        m_tlast;        // last_row
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	logic [ID_W-1:0]   own_id = '0;
	logic [TIME_W-1:0] own_expiry = EXPIRY_RESET;
	logic              own_valid = 1'b0;
	logic [RATE_W-1:0] own_rate = '0;
	logic [TIME_W-1:0] own_stamp = '0;
	entry_t            slots [MAX_OTHERS];
	int                fill = 0;
	row_t              pending_rows [$];

	int  errors = 0;
	int  n_items = 0;
	int  n_reports = 0;
	int  n_rows = 0;
	int  n_writes = 0;
	int  rx_hold = 0;
	bit  tx_steady = 1'b0;
	bit  rx_steady = 1'b0;

	top_k_rate_table_with_expiry #(.MAX_OTHERS(MAX_OTHERS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	function automatic int gap_len(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic is_stale(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] stamp);
		logic [TIME_W-1:0] age;
		age = now - stamp;
		return age > own_expiry;
	endfunction

	// Updates the table and returns the number of report rows queued.
	function automatic int apply_rate_item(input logic op, input logic [TIME_W-1:0] now,
			input logic [ID_W-1:0] id, input logic [RATE_W-1:0] rate);
		int i, j, kept, low;
		logic live_self;
		entry_t held;
		if (op == OP_UPDATE) begin
			if (id == own_id) begin
				own_valid = 1'b1;
				own_rate = rate;
				own_stamp = now;
				return 0;
			end
			for (i = 0; i < fill; i++) begin
				if (slots[i].id == id) begin
					slots[i].rate = rate;
					slots[i].stamp = now;
					return 0;
				end
			end
			if (fill < MAX_OTHERS) begin
				slots[fill] = '{id, rate, now};
				fill++;
				return 0;
			end
			low = 0;
			for (i = 1; i < fill; i++)
				if (slots[i].rate < slots[low].rate)
					low = i;
			slots[low] = '{id, rate, now};
			return 0;
		end
		kept = 0;
		for (i = 0; i < fill; i++) begin
			if (!is_stale(now, slots[i].stamp)) begin
				slots[kept] = slots[i];
				kept++;
			end
		end
		fill = kept;
		live_self = own_valid && !is_stale(now, own_stamp);
		for (i = 1; i < fill; i++) begin
			held = slots[i];
			j = i;
			while (j > 0 && slots[j-1].rate < held.rate) begin
				slots[j] = slots[j-1];
				j--;
			end
			slots[j] = held;
		end
		if (live_self)
			pending_rows.push_back('{1'b1, own_id, own_rate, fill == 0});
		for (i = 0; i < fill; i++)
			pending_rows.push_back('{1'b0, slots[i].id, slots[i].rate, i == fill - 1});
		return fill + (live_self ? 1 : 0);
	endfunction

	task automatic send_item(input logic op, input logic [TIME_W-1:0] now,
			input logic [ID_W-1:0] id, input logic [RATE_W-1:0] rate,
			output int made, output row_t first);
		int gap;
		s_tuser <= op;
		s_tdata <= {rate, id, now};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		made = apply_rate_item(op, now, id, rate);
		first = (made > 0) ? pending_rows[pending_rows.size() - made] : NO_ROW;
		n_items++;
		if (op == OP_REPORT)
			n_reports++;
		gap = gap_len(tx_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SELF_ID)
			own_id = data[ID_W-1:0];
		else
			own_expiry = data;
		n_writes++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_rows.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_tready <= 1'b1;
				rx_hold = gap_len(rx_steady);
			end
		end
	end

	always @(posedge clk) begin
		row_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[15:0], m_tdata[47:16], m_tlast};
			if (pending_rows.size() == 0) begin
				note_error($sformatf("unexpected row: self=%0d id=%h rate=%h last=%0d",
					got.is_self, got.id, got.rate, got.last));
			end else begin
				want = pending_rows.pop_front();
				n_rows++;
				if (got.is_self !== want.is_self || got.id !== want.id ||
						got.rate !== want.rate || got.last !== want.last)
					note_error($sformatf({"row mismatch: want self=%0d id=%h rate=%h last=%0d,",
						" got self=%0d id=%h rate=%h last=%0d"},
						want.is_self, want.id, want.rate, want.last,
						got.is_self, got.id, got.rate, got.last));
			end
		end
	end

	initial begin : stimulus
		int k, phase, made;
		row_t first;
		logic op;
		logic [ID_W-1:0] id;
		logic [RATE_W-1:0] rate;
		logic [TIME_W-1:0] clock_ms;
		logic [31:0] word;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[k]) begin
			if (PLAN[k].kind == STEP_CFG) begin
				wait_idle();
				write_reg(PLAN[k].sel, PLAN[k].word);
			end else begin
				send_item(PLAN[k].sel, PLAN[k].word, PLAN[k].id, PLAN[k].rate, made, first);
				if (PLAN[k].n_typed != NOT_TYPED &&
						(made != PLAN[k].n_typed || (made > 0 && first !== PLAN[k].first)))
					note_error($sformatf("directed step %0d: predicted %0d rows, first %h",
						k, made, first));
			end
		end

		clock_ms = $urandom;
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			tx_steady = (phase == 2);
			rx_steady = (phase == 4);
			word[31:16] = 16'($urandom);
			word[15:0] = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 9)) : 16'($urandom);
			write_reg(REG_SELF_ID, word);
			wait_idle();
			case (phase)
				0: word = EXPIRY_RESET;
				1: word = 32'd3000;
				default: begin
					case ($urandom_range(0, 4))
						0: word = 32'd0;
						1: word = 32'hFFFF_FFFF;
						2: word = EXPIRY_RESET;
						3: word = $urandom_range(500, 5000);
						default: word = $urandom;
					endcase
				end
			endcase
			write_reg(REG_EXPIRY, word);
			if (phase == 3)
				clock_ms = 32'hFFFF_E000;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(0, 19))
					0: clock_ms = $urandom;
					1: clock_ms = clock_ms - $urandom_range(0, 3000);
					default: clock_ms = clock_ms + $urandom_range(0, 2500);
				endcase
				op = ($urandom_range(0, 3) == 0) ? OP_REPORT : OP_UPDATE;
				if ($urandom_range(0, 6) == 0)
					id = own_id;
				else if ($urandom_range(0, 9) < 7)
					id = 16'($urandom_range(0, 6));
				else
					id = 16'($urandom);
				case ($urandom_range(0, 9))
					0: rate = 32'd0;
					1: rate = 32'hFFFF_FFFF;
					2, 3, 4: rate = $urandom_range(0, 3);
					default: rate = $urandom;
				endcase
				send_item(op, clock_ms, id, rate, made, first);
			end
		end

		wait_idle();
		$display("Sent %0d items (%0d reports) over %0d register writes; %0d rows compared.",
			n_items, n_reports, n_writes, n_rows);
		$display("Covered refresh, append, lowest-rate eviction, expiry purge and time wrap.");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
